>>> src/rnt_pkg.sv
// rnt_pkg: shared types and constants of the radius neighbor tracker
// request codes, event codes, field widths, controller to datapath command and status
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rnt_pkg;

    localparam int MAX_ACTORS_DEF = 8;
    localparam int COORD_BITS_DEF = 16;

    localparam int REQ_W    = 2;
    localparam int SLOT_W   = 3;
    localparam int POS_W    = 16;
    localparam int RADIUS_W = 16;
    localparam int R2_W     = 2 * RADIUS_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE  = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_TICK   = 2'd2
    } t_req;

    localparam logic EVT_ENTER = 1'b0;
    localparam logic EVT_LEAVE = 1'b1;

    typedef struct packed {
        logic              accept;
        logic              tick_issue;
        logic [SLOT_W-1:0] pair_obs;
        logic [SLOT_W-1:0] pair_oth;
        logic              rm_scan;
        logic              rm_phase_b;
        logic [SLOT_W-1:0] rm_idx;
        logic              flush;
        logic              rm_release;
    } t_dp_cmd;

    typedef struct packed {
        logic remove_ok;
    } t_dp_status;

endpackage

`default_nettype wire

>>> src/rnt_ram.sv
// rnt_ram: generic register file with one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rnt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    output logic      [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

>>> src/rnt_ctrl.sv
// rnt_ctrl: sequencer of the radius neighbor tracker
// walks observer/other pairs for a tick and the two scan phases of a remove
// depends on rnt_pkg
`timescale 1ns / 1ps
`default_nettype none

module rnt_ctrl #(
    parameter int MAX_ACTORS = rnt_pkg::MAX_ACTORS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [rnt_pkg::REQ_W-1:0]  i_req_type,
    input  wire rnt_pkg::t_dp_status        i_status,
    output rnt_pkg::t_dp_cmd                o_cmd,
    output logic                            o_busy
);

    import rnt_pkg::*;

    localparam int IW = $clog2(MAX_ACTORS);
    localparam logic [IW-1:0] LAST_IDX   = IW'(MAX_ACTORS - 1);
    localparam logic [1:0]    DRAIN_LAST = 2'd2;  // three pipeline stages after issue

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_TICK   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_REMOVE = 5'b01000,
        ST_FLUSH  = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_cnt_i, n_cnt_i;
    logic [IW-1:0] r_cnt_j, n_cnt_j;
    logic [1:0]    r_drain, n_drain;
    logic          r_phase_b, n_phase_b;
    logic          r_is_remove, n_is_remove;
    logic          w_accept;

    assign o_busy   = (r_state != ST_IDLE);
    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_state     = r_state;
        n_cnt_i     = r_cnt_i;
        n_cnt_j     = r_cnt_j;
        n_drain     = r_drain;
        n_phase_b   = r_phase_b;
        n_is_remove = r_is_remove;

        o_cmd            = '0;
        o_cmd.accept     = w_accept;
        o_cmd.pair_obs   = SLOT_W'(r_cnt_i);
        o_cmd.pair_oth   = SLOT_W'(r_cnt_j);
        o_cmd.rm_idx     = SLOT_W'(r_cnt_j);
        o_cmd.rm_phase_b = r_phase_b;

        case (r_state)
            ST_IDLE: begin
                n_cnt_i   = '0;
                n_cnt_j   = '0;
                n_phase_b = 1'b0;
                if (w_accept) begin
                    if (i_req_type == REQ_TICK) begin
                        n_state     = ST_TICK;
                        n_is_remove = 1'b0;
                    end else if (i_req_type == REQ_REMOVE && i_status.remove_ok) begin
                        n_state     = ST_REMOVE;
                        n_is_remove = 1'b1;
                    end
                end
            end
            ST_TICK: begin
                o_cmd.tick_issue = 1'b1;
                if (r_cnt_j == LAST_IDX) begin
                    n_cnt_j = '0;
                    n_cnt_i = r_cnt_i + 1'b1;
                    if (r_cnt_i == LAST_IDX) begin
                        n_state = ST_DRAIN;
                        n_drain = '0;
                    end
                end else begin
                    n_cnt_j = r_cnt_j + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_drain = r_drain + 1'b1;
                if (r_drain == DRAIN_LAST) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_REMOVE: begin
                o_cmd.rm_scan = 1'b1;
                if (r_cnt_j == LAST_IDX) begin
                    n_cnt_j = '0;
                    if (r_phase_b) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_phase_b = 1'b1;
                    end
                end else begin
                    n_cnt_j = r_cnt_j + 1'b1;
                end
            end
            ST_FLUSH: begin
                o_cmd.flush      = 1'b1;
                o_cmd.rm_release = r_is_remove;
                n_state          = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_i     <= '0;
            r_cnt_j     <= '0;
            r_drain     <= '0;
            r_phase_b   <= 1'b0;
            r_is_remove <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_i     <= n_cnt_i;
            r_cnt_j     <= n_cnt_j;
            r_drain     <= n_drain;
            r_phase_b   <= n_phase_b;
            r_is_remove <= n_is_remove;
        end
    end

endmodule

`default_nettype wire

>>> src/rnt_datapath.sv
// rnt_datapath: slot table, neighbor matrix, distance pipeline and event output
// pair pipeline: table read, difference, squares, compare and row update
// depends on rnt_pkg and rnt_ram
`timescale 1ns / 1ps
`default_nettype none

module rnt_datapath #(
    parameter int MAX_ACTORS = rnt_pkg::MAX_ACTORS_DEF,
    parameter int COORD_BITS = rnt_pkg::COORD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire rnt_pkg::t_dp_cmd                 i_cmd,
    input  wire logic [rnt_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic [rnt_pkg::SLOT_W-1:0]       i_slot,
    input  wire logic signed [rnt_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [rnt_pkg::POS_W-1:0] i_pos_y,
    input  wire logic [rnt_pkg::RADIUS_W-1:0]     i_radius,
    output rnt_pkg::t_dp_status                   o_status,
    output logic                                  o_strobe,
    output logic                                  o_event_kind,
    output logic [rnt_pkg::SLOT_W-1:0]            o_observer_slot,
    output logic [rnt_pkg::SLOT_W-1:0]            o_other_slot,
    output logic                                  o_last
);

    import rnt_pkg::*;

    localparam int IW    = $clog2(MAX_ACTORS);
    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 1;
    localparam int SQW   = 2 * DW;
    localparam int SUMW  = SQW + 1;
    localparam int CW    = (SUMW > R2_W) ? SUMW : R2_W;
    localparam int ENT_W = 2 * CB + RADIUS_W;

    // slot table entry layout {x, y, radius}
    logic signed [CB-1:0] w_pos_x, w_pos_y;
    logic [ENT_W-1:0]     w_rd_a, w_rd_b;
    logic                 w_slot_in_range;
    logic [IW-1:0]        w_slot_idx;
    logic                 w_wr_en;

    logic                    r_active [MAX_ACTORS];
    logic [MAX_ACTORS-1:0]   r_rows   [MAX_ACTORS];
    logic [IW-1:0]           r_rm_slot;

    // pair pipeline
    logic [IW-1:0]        w_pi, w_pj;
    logic                 w_pair_ok;
    logic                 r_v1, r_v2, r_v3;
    logic [IW-1:0]        r_i1, r_j1, r_i2, r_j2, r_i3, r_j3;
    logic signed [DW-1:0] r_dx, r_dy;
    logic [RADIUS_W-1:0]  r_rad;
    logic signed [SQW-1:0] w_sqx, w_sqy;
    logic [SQW-1:0]       r_sqx, r_sqy;
    logic [R2_W-1:0]      r_r2;
    logic [SUMW-1:0]      w_d2;
    logic                 w_inside, w_had;

    // remove scan
    logic [IW-1:0] w_rm_idx;
    logic          w_rm_hit_a, w_rm_hit_b;

    // event stage
    logic          w_new_evt;
    logic          w_new_kind;
    logic [IW-1:0] w_new_obs, w_new_oth;
    logic          r_pend_valid;
    logic          r_pend_kind;
    logic [IW-1:0] r_pend_obs, r_pend_oth;
    logic          r_out_kind, r_out_last;
    logic [IW-1:0] r_out_obs, r_out_oth;

    generate
        if (CB <= POS_W) begin : g_pos_trunc
            assign w_pos_x = i_pos_x[CB-1:0];
            assign w_pos_y = i_pos_y[CB-1:0];
        end else begin : g_pos_ext
            // a narrower field is widened with its sign
            assign w_pos_x = {{(CB - POS_W){i_pos_x[POS_W-1]}}, i_pos_x};
            assign w_pos_y = {{(CB - POS_W){i_pos_y[POS_W-1]}}, i_pos_y};
        end
    endgenerate

    assign w_slot_in_range   = ({1'b0, i_slot} < (SLOT_W + 1)'(MAX_ACTORS));
    assign w_slot_idx        = i_slot[IW-1:0];
    assign w_wr_en           = i_cmd.accept && (i_req_type == REQ_WRITE) && w_slot_in_range;
    assign o_status.remove_ok = w_slot_in_range && r_active[w_slot_idx];

    assign w_pi = i_cmd.pair_obs[IW-1:0];
    assign w_pj = i_cmd.pair_oth[IW-1:0];
    assign w_pair_ok = i_cmd.tick_issue && r_active[w_pi] && r_active[w_pj] && (w_pi != w_pj);

    rnt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ACTORS)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_slot_idx),
        .i_wr_data   ({w_pos_x, w_pos_y, i_radius}),
        .i_rd_addr_a (w_pi),
        .i_rd_addr_b (w_pj),
        .o_rd_data_a (w_rd_a),
        .o_rd_data_b (w_rd_b)
    );

    assign w_sqx = r_dx * r_dx;
    assign w_sqy = r_dy * r_dy;
    assign w_d2  = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign w_inside = (CW'(w_d2) <= CW'(r_r2));
    assign w_had    = r_rows[r_i3][r_j3];

    assign w_rm_idx   = i_cmd.rm_idx[IW-1:0];
    assign w_rm_hit_a = i_cmd.rm_scan && !i_cmd.rm_phase_b && (w_rm_idx != r_rm_slot)
                        && r_rows[w_rm_idx][r_rm_slot];
    assign w_rm_hit_b = i_cmd.rm_scan && i_cmd.rm_phase_b && r_rows[r_rm_slot][w_rm_idx];

    always_comb begin
        w_new_evt  = 1'b0;
        w_new_kind = EVT_LEAVE;
        w_new_obs  = r_i3;
        w_new_oth  = r_j3;
        if (r_v3 && (w_inside != w_had)) begin
            w_new_evt  = 1'b1;
            w_new_kind = w_had ? EVT_LEAVE : EVT_ENTER;
        end else if (w_rm_hit_a) begin
            w_new_evt = 1'b1;
            w_new_obs = w_rm_idx;
            w_new_oth = r_rm_slot;
        end else if (w_rm_hit_b) begin
            w_new_evt = 1'b1;
            w_new_obs = r_rm_slot;
            w_new_oth = w_rm_idx;
        end
    end

    // slot state and neighbor matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_ACTORS; k++) begin
                r_active[k] <= 1'b0;
                r_rows[k]   <= '0;
            end
        end else begin
            if (w_wr_en) begin
                if (!r_active[w_slot_idx]) begin
                    r_rows[w_slot_idx] <= '0;
                end
                r_active[w_slot_idx] <= 1'b1;
            end
            if (r_v3) begin
                r_rows[r_i3][r_j3] <= w_inside;
            end
            if (w_rm_hit_a) begin
                r_rows[w_rm_idx][r_rm_slot] <= 1'b0;
            end
            if (i_cmd.rm_release) begin
                r_rows[r_rm_slot]   <= '0;
                r_active[r_rm_slot] <= 1'b0;
            end
        end
    end

    // pipeline and event control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_pend_valid <= 1'b0;
            o_strobe     <= 1'b0;
        end else begin
            r_v1     <= w_pair_ok;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            o_strobe <= r_pend_valid && (w_new_evt || i_cmd.flush);
            if (w_new_evt) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rm_slot <= w_slot_idx;
        end
        r_i1  <= w_pi;
        r_j1  <= w_pj;
        r_i2  <= r_i1;
        r_j2  <= r_j1;
        r_i3  <= r_i2;
        r_j3  <= r_j2;
        r_dx  <= $signed({w_rd_a[ENT_W-1], w_rd_a[ENT_W-1 -: CB]})
               - $signed({w_rd_b[ENT_W-1], w_rd_b[ENT_W-1 -: CB]});
        r_dy  <= $signed({w_rd_a[RADIUS_W+CB-1], w_rd_a[RADIUS_W+CB-1 -: CB]})
               - $signed({w_rd_b[RADIUS_W+CB-1], w_rd_b[RADIUS_W+CB-1 -: CB]});
        r_rad <= w_rd_a[RADIUS_W-1:0];
        r_sqx <= w_sqx;
        r_sqy <= w_sqy;
        r_r2  <= R2_W'(r_rad) * R2_W'(r_rad);
        if (w_new_evt) begin
            r_pend_kind <= w_new_kind;
            r_pend_obs  <= w_new_obs;
            r_pend_oth  <= w_new_oth;
        end
        // the held word goes out once the next one shows up or the item ends
        if (w_new_evt || i_cmd.flush) begin
            r_out_kind <= r_pend_kind;
            r_out_obs  <= r_pend_obs;
            r_out_oth  <= r_pend_oth;
            r_out_last <= !w_new_evt;
        end
    end

    assign o_event_kind    = r_out_kind;
    assign o_observer_slot = SLOT_W'(r_out_obs);
    assign o_other_slot    = SLOT_W'(r_out_oth);
    assign o_last          = r_out_last;

endmodule

`default_nettype wire

>>> src/radius_neighbor_tracker.sv
// radius_neighbor_tracker: top level, sequencer plus datapath
// depends on rnt_pkg, rnt_ctrl, rnt_datapath
//
// Usage: a request word (write, remove or tick) is taken at a rising edge with
// start high and busy low. Event words come out on o_event_kind,
// o_observer_slot and o_other_slot, each for one cycle with o_strobe high;
// o_last marks the final word of a request. The receiver cannot stall the
// block, so every strobed word must be captured when it appears.
// Write: busy stays low, no events.
// Remove of an active slot: busy for two scans over the neighbor matrix, one
// slot a cycle, then a flush; up to 2*(MAX_ACTORS-1) events, the last one the
// cycle busy drops.
// Tick: one pair enters the distance pipeline per cycle, the pipeline is three
// stages deep, then a flush. Events come out in pair order; each word is held
// until the next one is known, so the final word appears the cycle busy drops.
// Reset (i_rst_n low, synchronous) deactivates every slot, clears all
// neighbor bits and drops any pending events.
`timescale 1ns / 1ps
`default_nettype none

module radius_neighbor_tracker #(
    parameter int MAX_ACTORS = rnt_pkg::MAX_ACTORS_DEF,
    parameter int COORD_BITS = rnt_pkg::COORD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [rnt_pkg::REQ_W-1:0]        i_req_type,
    input  wire logic [rnt_pkg::SLOT_W-1:0]       i_slot,
    input  wire logic signed [rnt_pkg::POS_W-1:0] i_pos_x,
    input  wire logic signed [rnt_pkg::POS_W-1:0] i_pos_y,
    input  wire logic [rnt_pkg::RADIUS_W-1:0]     i_radius,
    output logic                                  o_strobe,
    output logic                                  o_event_kind,
    output logic [rnt_pkg::SLOT_W-1:0]            o_observer_slot,
    output logic [rnt_pkg::SLOT_W-1:0]            o_other_slot,
    output logic                                  o_last
);

    import rnt_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    rnt_ctrl #(
        .MAX_ACTORS (MAX_ACTORS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (busy)
    );

    rnt_datapath #(
        .MAX_ACTORS (MAX_ACTORS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_req_type      (i_req_type),
        .i_slot          (i_slot),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_radius        (i_radius),
        .o_status        (w_status),
        .o_strobe        (o_strobe),
        .o_event_kind    (o_event_kind),
        .o_observer_slot (o_observer_slot),
        .o_other_slot    (o_other_slot),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

>>> src/rnt_checker.sv
// rnt_checker: port-level checks of the radius neighbor tracker, bound to the top level
// depends on rnt_pkg and radius_neighbor_tracker
`timescale 1ns / 1ps
`default_nettype none

module rnt_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic [rnt_pkg::REQ_W-1:0]  i_req_type,
    input wire logic                       o_strobe,
    input wire logic [rnt_pkg::SLOT_W-1:0] o_observer_slot,
    input wire logic [rnt_pkg::SLOT_W-1:0] o_other_slot,
    input wire logic                       o_last
);

    import rnt_pkg::*;

    // every word is produced by work done while busy
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("event word without preceding work");

    // a tick always takes the sequencer out of idle
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == REQ_TICK) |=> busy)
        else $error("tick request did not start a pass");

    // the last word of a request comes out as the block frees up
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("last word while still busy");

    // a word that is not the last comes out while the request is still running
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("non-last word after the request ended");

    // a slot never observes itself
    a_no_self_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_observer_slot != o_other_slot))
        else $error("event pairs a slot with itself");

endmodule

bind radius_neighbor_tracker rnt_checker u_rnt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_req_type      (i_req_type),
    .o_strobe        (o_strobe),
    .o_observer_slot (o_observer_slot),
    .o_other_slot    (o_other_slot),
    .o_last          (o_last)
);

`default_nettype wire
